[rtl/core/v2alu_pkg.sv]
// Shared types, constants and helpers for the 2D vector arithmetic unit.
// No dependencies.
package v2alu_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int QW          = 33;
  localparam int DW          = 32 + FRAC_BITS;
  localparam int SQRT_STAGES = 32;

  localparam logic [3:0] ACT_ADD  = 4'd0;
  localparam logic [3:0] ACT_SUB  = 4'd1;
  localparam logic [3:0] ACT_MUL  = 4'd2;
  localparam logic [3:0] ACT_DIV  = 4'd3;
  localparam logic [3:0] ACT_SCL  = 4'd4;
  localparam logic [3:0] ACT_SDIV = 4'd5;
  localparam logic [3:0] ACT_EQ   = 4'd6;
  localparam logic [3:0] ACT_NE   = 4'd7;
  localparam logic [3:0] ACT_MAG  = 4'd8;
  localparam logic [3:0] ACT_NORM = 4'd9;
  localparam logic [3:0] ACT_DIST = 4'd10;
  localparam logic [3:0] ACT_DOT  = 4'd11;

  localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;

  typedef struct packed {
    logic [3:0]         act;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [31:0]        dvx;
    logic [31:0]        dvy;
    logic               dsx;
    logic               dsy;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rs;
    logic               cmp;
    logic               sat;
    logic               big;
  } side_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               s;
  } clamp_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               sat;
    logic               dz;
  } qres_t;

  function automatic clamp_t clamp32(input logic signed [65:0] v);
    clamp_t c;
    c.s = 1'b0;
    c.v = v[31:0];
    if (v > 66'sd2147483647) begin
      c.v = MAX32;
      c.s = 1'b1;
    end else if (v < -66'sd2147483648) begin
      c.v = MIN32;
      c.s = 1'b1;
    end
    return c;
  endfunction

endpackage

[rtl/core/vector2_arithmetic_unit_top.sv]
// Top level of the 2D vector arithmetic unit: operand prep, multipliers,
// square root and divider pipelines. Depends on v2alu_pkg, v2alu_sqrt, v2alu_div.
//
// One item is taken on every clock edge at which start is high; busy is never
// raised. Every item, whatever its action, runs the same fixed pipeline and its
// result is shown for one cycle with done high; the depth of the pipeline is set
// by the 32-stage square root followed by the 33-stage divider, which normalise
// needs in sequence. Results come out in order.

module vector2_arithmetic_unit_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         action,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] scale_value,
  output logic               done,
  output logic signed [31:0] result_x,
  output logic signed [31:0] result_y,
  output logic signed [31:0] result_scalar,
  output logic               compare_true,
  output logic               divide_by_zero,
  output logic               saturated
);

  assign busy = 1'b0;

  logic               v1;
  logic [3:0]         s1_act;
  logic signed [31:0] s1_ax, s1_ay, s1_bx, s1_by, s1_sv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    s1_act <= action;
    s1_ax  <= a_x;
    s1_ay  <= a_y;
    s1_bx  <= b_x;
    s1_by  <= b_y;
    s1_sv  <= scale_value;
  end

  logic signed [32:0] sum_x, sum_y, dif_x, dif_y;
  v2alu_pkg::clamp_t  c_ax, c_ay, c_sx, c_sy;
  logic signed [31:0] op0, op1, op2, op3;
  logic signed [31:0] p_rx, p_ry;
  logic               p_cmp, p_sat, p_big, eqv;

  always_comb begin
    sum_x = 33'(s1_ax) + 33'(s1_bx);
    sum_y = 33'(s1_ay) + 33'(s1_by);
    dif_x = 33'(s1_ax) - 33'(s1_bx);
    dif_y = 33'(s1_ay) - 33'(s1_by);
    c_ax  = v2alu_pkg::clamp32(66'(sum_x));
    c_ay  = v2alu_pkg::clamp32(66'(sum_y));
    c_sx  = v2alu_pkg::clamp32(66'(dif_x));
    c_sy  = v2alu_pkg::clamp32(66'(dif_y));
    eqv   = (s1_ax == s1_bx) && (s1_ay == s1_by);
    op0 = '0; op1 = '0; op2 = '0; op3 = '0;
    p_rx = '0; p_ry = '0; p_cmp = 1'b0; p_sat = 1'b0; p_big = 1'b0;
    case (s1_act)
      v2alu_pkg::ACT_ADD: begin
        p_rx = c_ax.v; p_ry = c_ay.v; p_sat = c_ax.s | c_ay.s;
      end
      v2alu_pkg::ACT_SUB: begin
        p_rx = c_sx.v; p_ry = c_sy.v; p_sat = c_sx.s | c_sy.s;
      end
      v2alu_pkg::ACT_MUL, v2alu_pkg::ACT_DOT: begin
        op0 = s1_ax; op1 = s1_bx; op2 = s1_ay; op3 = s1_by;
      end
      v2alu_pkg::ACT_SCL: begin
        op0 = s1_ax; op1 = s1_sv; op2 = s1_ay; op3 = s1_sv;
      end
      v2alu_pkg::ACT_EQ:  p_cmp = eqv;
      v2alu_pkg::ACT_NE:  p_cmp = !eqv;
      v2alu_pkg::ACT_MAG, v2alu_pkg::ACT_NORM: begin
        op0 = s1_ax; op1 = s1_ax; op2 = s1_ay; op3 = s1_ay;
        p_big = (s1_act == v2alu_pkg::ACT_MAG) &&
                ((s1_ax == v2alu_pkg::MIN32) || (s1_ay == v2alu_pkg::MIN32));
      end
      v2alu_pkg::ACT_DIST: begin
        op0 = $signed(dif_x[31:0]); op1 = op0;
        op2 = $signed(dif_y[31:0]); op3 = op2;
        p_big = (dif_x > 33'sd2147483647) || (dif_x < -33'sd2147483647) ||
                (dif_y > 33'sd2147483647) || (dif_y < -33'sd2147483647);
      end
      default: ;
    endcase
  end

  logic               v2;
  logic [3:0]         s2_act;
  logic signed [31:0] s2_ax, s2_ay, s2_bx, s2_by, s2_sv;
  logic signed [31:0] s2_op0, s2_op1, s2_op2, s2_op3, s2_rx, s2_ry;
  logic               s2_cmp, s2_sat, s2_big;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2_act <= s1_act;
    s2_ax  <= s1_ax;
    s2_ay  <= s1_ay;
    s2_bx  <= s1_bx;
    s2_by  <= s1_by;
    s2_sv  <= s1_sv;
    s2_op0 <= op0;
    s2_op1 <= op1;
    s2_op2 <= op2;
    s2_op3 <= op3;
    s2_rx  <= p_rx;
    s2_ry  <= p_ry;
    s2_cmp <= p_cmp;
    s2_sat <= p_sat;
    s2_big <= p_big;
  end

  logic               v3;
  logic [3:0]         s3_act;
  logic signed [31:0] s3_ax, s3_ay, s3_bx, s3_by, s3_sv, s3_rx, s3_ry;
  logic signed [63:0] s3_p0, s3_p1;
  logic               s3_cmp, s3_sat, s3_big;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3_act <= s2_act;
    s3_ax  <= s2_ax;
    s3_ay  <= s2_ay;
    s3_bx  <= s2_bx;
    s3_by  <= s2_by;
    s3_sv  <= s2_sv;
    s3_rx  <= s2_rx;
    s3_ry  <= s2_ry;
    s3_cmp <= s2_cmp;
    s3_sat <= s2_sat;
    s3_big <= s2_big;
    s3_p0  <= s2_op0 * s2_op1;
    s3_p1  <= s2_op2 * s2_op3;
  end

  logic signed [64:0] psum;
  v2alu_pkg::clamp_t  c_m0, c_m1, c_dot;
  v2alu_pkg::side_t   side3;
  logic [63:0]        n3;

  always_comb begin
    psum  = 65'(s3_p0) + 65'(s3_p1);
    c_m0  = v2alu_pkg::clamp32(66'(s3_p0 >>> v2alu_pkg::FRAC_BITS));
    c_m1  = v2alu_pkg::clamp32(66'(s3_p1 >>> v2alu_pkg::FRAC_BITS));
    c_dot = v2alu_pkg::clamp32(66'(psum >>> v2alu_pkg::FRAC_BITS));
    n3    = $unsigned(s3_p0) + $unsigned(s3_p1);
    side3     = '0;
    side3.act = s3_act;
    side3.rx  = s3_rx;
    side3.ry  = s3_ry;
    side3.cmp = s3_cmp;
    side3.sat = s3_sat;
    side3.big = s3_big;
    side3.nx  = s3_ax;
    side3.ny  = s3_ay;
    case (s3_act)
      v2alu_pkg::ACT_MUL, v2alu_pkg::ACT_SCL: begin
        side3.rx  = c_m0.v;
        side3.ry  = c_m1.v;
        side3.sat = c_m0.s | c_m1.s;
      end
      v2alu_pkg::ACT_DOT: begin
        side3.rs  = c_dot.v;
        side3.sat = c_dot.s;
      end
      v2alu_pkg::ACT_DIV: begin
        side3.dvx = s3_bx[31] ? (~$unsigned(s3_bx) + 32'd1) : $unsigned(s3_bx);
        side3.dvy = s3_by[31] ? (~$unsigned(s3_by) + 32'd1) : $unsigned(s3_by);
        side3.dsx = s3_bx[31];
        side3.dsy = s3_by[31];
      end
      v2alu_pkg::ACT_SDIV: begin
        side3.dvx = s3_sv[31] ? (~$unsigned(s3_sv) + 32'd1) : $unsigned(s3_sv);
        side3.dvy = side3.dvx;
        side3.dsx = s3_sv[31];
        side3.dsy = s3_sv[31];
      end
      default: ;
    endcase
  end

  logic             v4;
  v2alu_pkg::side_t s4_side;
  logic [63:0]      s4_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4_side <= side3;
    s4_n    <= n3;
  end

  logic             sq_valid;
  v2alu_pkg::side_t sq_side;
  logic [31:0]      sq_root;

  v2alu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_side   (s4_side),
    .in_n      (s4_n),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_root  (sq_root)
  );

  v2alu_pkg::side_t side5;

  always_comb begin
    side5 = sq_side;
    case (sq_side.act)
      v2alu_pkg::ACT_MAG, v2alu_pkg::ACT_DIST: begin
        if (sq_side.big || (sq_root > 32'h7fffffff)) begin
          side5.rs  = v2alu_pkg::MAX32;
          side5.sat = 1'b1;
        end else begin
          side5.rs = $signed(sq_root);
        end
      end
      v2alu_pkg::ACT_NORM: begin
        side5.dvx = sq_root;
        side5.dvy = sq_root;
        side5.dsx = 1'b0;
        side5.dsy = 1'b0;
      end
      default: ;
    endcase
  end

  logic             v5;
  v2alu_pkg::side_t s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= sq_valid;
    end
    s5_side <= side5;
  end

  logic             dv_valid;
  v2alu_pkg::side_t dv_side;
  v2alu_pkg::qres_t dv_qx, dv_qy;

  v2alu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_side   (s5_side),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_qx    (dv_qx),
    .out_qy    (dv_qy)
  );

  logic isdiv;

  assign isdiv = (dv_side.act == v2alu_pkg::ACT_DIV) || (dv_side.act == v2alu_pkg::ACT_SDIV) ||
                 (dv_side.act == v2alu_pkg::ACT_NORM);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    result_x       <= isdiv ? dv_qx.v : dv_side.rx;
    result_y       <= isdiv ? dv_qy.v : dv_side.ry;
    result_scalar  <= dv_side.rs;
    compare_true   <= dv_side.cmp;
    divide_by_zero <= isdiv && (dv_qx.dz || dv_qy.dz);
    saturated      <= dv_side.sat || (isdiv && (dv_qx.sat || dv_qy.sat));
  end

  a_latency: assert property (@(posedge clk) disable iff (rst) start |-> ##73 done)
    else $error("result strobe missing after transfer");

  a_cmp_flags: assert property (@(posedge clk) disable iff (rst)
    done && compare_true |-> !saturated && !divide_by_zero)
    else $error("compare result carries arithmetic flags");

  a_dz_scalar: assert property (@(posedge clk) disable iff (rst)
    done && divide_by_zero |-> result_scalar == 32'sd0)
    else $error("divide by zero on scalar result");

endmodule

[rtl/core/v2alu_sqrt.sv]
// Pipelined integer square root, one root bit per stage, sideband carried along.
// Depends on v2alu_pkg.
module v2alu_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  v2alu_pkg::side_t    in_side,
  input  logic [63:0]         in_n,
  output logic                out_valid,
  output v2alu_pkg::side_t    out_side,
  output logic [31:0]         out_root
);

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] nlo;
  } sq_t;

  logic                vld  [v2alu_pkg::SQRT_STAGES+1];
  v2alu_pkg::side_t    side [v2alu_pkg::SQRT_STAGES+1];
  sq_t                 st   [v2alu_pkg::SQRT_STAGES+1];

  assign vld[0]  = in_valid;
  assign side[0] = in_side;
  assign st[0]   = '{rem: 34'd0, root: 32'd0, nlo: in_n};

  for (genvar i = 0; i < v2alu_pkg::SQRT_STAGES; i++) begin : g_stage
    logic [35:0] r4;
    logic [35:0] trial;
    logic        ge;
    sq_t         nxt;

    always_comb begin
      r4        = {st[i].rem, st[i].nlo[63:62]};
      trial     = {2'b00, st[i].root, 2'b01};
      ge        = r4 >= trial;
      nxt.rem   = ge ? 34'(r4 - trial) : r4[33:0];
      nxt.root  = {st[i].root[30:0], ge};
      nxt.nlo   = {st[i].nlo[61:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      side[i+1] <= side[i];
      st[i+1]   <= nxt;
    end
  end

  assign out_valid = vld[v2alu_pkg::SQRT_STAGES];
  assign out_side  = side[v2alu_pkg::SQRT_STAGES];
  assign out_root  = st[v2alu_pkg::SQRT_STAGES].root;

endmodule

[rtl/core/v2alu_div.sv]
// Pipelined two-lane signed fixed-point divider, one quotient bit per stage,
// with zero-divisor and overflow clamping. Depends on v2alu_pkg.
module v2alu_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  v2alu_pkg::side_t    in_side,
  output logic                out_valid,
  output v2alu_pkg::side_t    out_side,
  output v2alu_pkg::qres_t    out_qx,
  output v2alu_pkg::qres_t    out_qy
);

  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] q;
    logic [32:0] dlo;
    logic [31:0] d;
    logic        neg;
    logic        dz;
    logic        ovf;
    logic        npos;
    logic        nneg;
  } dl_t;

  function automatic dl_t setup(input logic signed [31:0] n, input logic [31:0] d,
                                input logic ds);
    dl_t                      l;
    logic [31:0]              mag;
    logic [v2alu_pkg::DW-1:0] dd;
    mag    = n[31] ? (~$unsigned(n) + 32'd1) : $unsigned(n);
    dd     = {mag, {v2alu_pkg::FRAC_BITS{1'b0}}};
    l.rem  = 32'(dd >> v2alu_pkg::QW);
    l.q    = '0;
    l.dlo  = dd[v2alu_pkg::QW-1:0];
    l.d    = d;
    l.neg  = n[31] ^ ds;
    l.dz   = (d == 32'd0);
    l.ovf  = 65'(dd) >= {d, {v2alu_pkg::QW{1'b0}}};
    l.npos = !n[31] && (n != 32'sd0);
    l.nneg = n[31];
    return l;
  endfunction

  function automatic dl_t iter(input dl_t l);
    dl_t         o;
    logic [32:0] r2;
    logic        ge;
    o     = l;
    r2    = {l.rem, l.dlo[32]};
    ge    = r2 >= {1'b0, l.d};
    o.rem = ge ? 32'(r2 - {1'b0, l.d}) : r2[31:0];
    o.q   = {l.q[31:0], ge};
    o.dlo = {l.dlo[31:0], 1'b0};
    return o;
  endfunction

  function automatic v2alu_pkg::qres_t fin(input dl_t l);
    v2alu_pkg::qres_t r;
    r.dz  = l.dz;
    r.sat = 1'b0;
    if (l.dz) begin
      r.v = l.npos ? v2alu_pkg::MAX32 : (l.nneg ? v2alu_pkg::MIN32 : 32'sd0);
    end else if (l.ovf) begin
      r.sat = 1'b1;
      r.v   = l.neg ? v2alu_pkg::MIN32 : v2alu_pkg::MAX32;
    end else if (!l.neg) begin
      if (l.q > 33'h07fffffff) begin
        r.sat = 1'b1;
        r.v   = v2alu_pkg::MAX32;
      end else begin
        r.v = $signed(l.q[31:0]);
      end
    end else begin
      if (l.q > 33'h080000000) begin
        r.sat = 1'b1;
        r.v   = v2alu_pkg::MIN32;
      end else begin
        r.v = $signed(~l.q[31:0] + 32'd1);
      end
    end
    return r;
  endfunction

  logic             vld  [v2alu_pkg::QW+1];
  v2alu_pkg::side_t side [v2alu_pkg::QW+1];
  dl_t              lx   [v2alu_pkg::QW+1];
  dl_t              ly   [v2alu_pkg::QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    side[0] <= in_side;
    lx[0]   <= setup(in_side.nx, in_side.dvx, in_side.dsx);
    ly[0]   <= setup(in_side.ny, in_side.dvy, in_side.dsy);
  end

  for (genvar i = 0; i < v2alu_pkg::QW; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      side[i+1] <= side[i];
      lx[i+1]   <= iter(lx[i]);
      ly[i+1]   <= iter(ly[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[v2alu_pkg::QW];
    end
    out_side <= side[v2alu_pkg::QW];
    out_qx   <= fin(lx[v2alu_pkg::QW]);
    out_qy   <= fin(ly[v2alu_pkg::QW]);
  end

endmodule

[sim/vector2_arithmetic_unit_top_tb.sv]
// Testbench for vector2_arithmetic_unit_top: directed and random vector operations
// scored against an in-bench arithmetic predictor. Depends on v2alu_pkg and the RTL.
module vector2_arithmetic_unit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 73;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rs;
    logic               cmp;
    logic               dz;
    logic               sat;
  } vec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [3:0] action = '0;
  logic signed [31:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0, scale_value = '0;
  logic done;
  logic signed [31:0] result_x, result_y, result_scalar;
  logic compare_true, divide_by_zero, saturated;

  vec_result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  longint cycles = 0;

  vector2_arithmetic_unit_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y), .scale_value(scale_value),
    .done(done), .result_x(result_x), .result_y(result_y),
    .result_scalar(result_scalar), .compare_true(compare_true),
    .divide_by_zero(divide_by_zero), .saturated(saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [31:0] sat32(input logic signed [127:0] v,
                                               inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return v2alu_pkg::MAX32;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return v2alu_pkg::MIN32;
    end
    return v[31:0];
  endfunction

  // >>> on a signed value floors
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                inout logic sat);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    return sat32(p >>> v2alu_pkg::FRAC_BITS, sat);
  endfunction

  function automatic logic signed [31:0] fx_div(input logic signed [127:0] a,
                                                input logic signed [127:0] b,
                                                inout logic dz, inout logic sat);
    logic signed [127:0] q;
    if (b == 0) begin
      dz = 1'b1;
      if (a > 0) return v2alu_pkg::MAX32;
      if (a < 0) return v2alu_pkg::MIN32;
      return '0;
    end
    q = (a <<< v2alu_pkg::FRAC_BITS) / b;
    return sat32(q, sat);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [127:0] n);
    logic [127:0] lo, hi, mid;
    lo = '0;
    hi = 128'h1_0000_0000_0000_0000;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    return lo[63:0];
  endfunction

  function automatic logic signed [31:0] vec_length(input logic signed [127:0] x,
                                                    input logic signed [127:0] y,
                                                    inout logic sat);
    logic signed [127:0] l;
    if (x > 128'sd2147483647 || x < -128'sd2147483647 ||
        y > 128'sd2147483647 || y < -128'sd2147483647) begin
      sat = 1'b1;
      return v2alu_pkg::MAX32;
    end
    l = $signed({64'd0, int_sqrt(x * x + y * y)});
    return sat32(l, sat);
  endfunction

  function automatic vec_result_t predict_vector_op(input logic [3:0] act,
      input logic signed [31:0] ax, input logic signed [31:0] ay,
      input logic signed [31:0] bx, input logic signed [31:0] by,
      input logic signed [31:0] sv);
    vec_result_t r;
    logic signed [127:0] len;
    r = '{default: '0};
    case (act)
      v2alu_pkg::ACT_ADD: begin
        r.rx = sat32(128'(ax) + 128'(bx), r.sat);
        r.ry = sat32(128'(ay) + 128'(by), r.sat);
      end
      v2alu_pkg::ACT_SUB: begin
        r.rx = sat32(128'(ax) - 128'(bx), r.sat);
        r.ry = sat32(128'(ay) - 128'(by), r.sat);
      end
      v2alu_pkg::ACT_MUL: begin
        r.rx = fx_mul(ax, bx, r.sat);
        r.ry = fx_mul(ay, by, r.sat);
      end
      v2alu_pkg::ACT_DIV: begin
        r.rx = fx_div(128'(ax), 128'(bx), r.dz, r.sat);
        r.ry = fx_div(128'(ay), 128'(by), r.dz, r.sat);
      end
      v2alu_pkg::ACT_SCL: begin
        r.rx = fx_mul(ax, sv, r.sat);
        r.ry = fx_mul(ay, sv, r.sat);
      end
      v2alu_pkg::ACT_SDIV: begin
        r.rx = fx_div(128'(ax), 128'(sv), r.dz, r.sat);
        r.ry = fx_div(128'(ay), 128'(sv), r.dz, r.sat);
      end
      v2alu_pkg::ACT_EQ: r.cmp = (ax == bx) && (ay == by);
      v2alu_pkg::ACT_NE: r.cmp = !((ax == bx) && (ay == by));
      v2alu_pkg::ACT_MAG: r.rs = vec_length(128'(ax), 128'(ay), r.sat);
      v2alu_pkg::ACT_NORM: begin
        len = $signed({64'd0, int_sqrt(128'(ax) * 128'(ax) + 128'(ay) * 128'(ay))});
        if (len == 0) begin
          r.dz = 1'b1;
        end else begin
          r.rx = fx_div(128'(ax), len, r.dz, r.sat);
          r.ry = fx_div(128'(ay), len, r.dz, r.sat);
        end
      end
      v2alu_pkg::ACT_DIST:
        r.rs = vec_length(128'(ax) - 128'(bx), 128'(ay) - 128'(by), r.sat);
      v2alu_pkg::ACT_DOT:
        r.rs = sat32((128'(ax) * 128'(bx) + 128'(ay) * 128'(by)) >>> v2alu_pkg::FRAC_BITS,
                     r.sat);
      default: ;
    endcase
    return r;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? int'($urandom_range(10, 60))
                                     : int'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_vector_op(input logic [3:0] act,
      input logic signed [31:0] ax, input logic signed [31:0] ay,
      input logic signed [31:0] bx, input logic signed [31:0] by,
      input logic signed [31:0] sv, input bit gaps);
    start <= 1'b1;
    action <= act;
    a_x <= ax;
    a_y <= ay;
    b_x <= bx;
    b_y <= by;
    scale_value <= sv;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_vector_op(act, ax, ay, bx, by, sv));
    items_sent++;
    if (gaps && $urandom_range(0, 1) == 0) begin
      idle_gap();
    end
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return v2alu_pkg::MAX32;
      1: return v2alu_pkg::MIN32;
      2: return '0;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      4: return $signed($urandom_range(0, 32'h3ff) << v2alu_pkg::FRAC_BITS) - 32'sh2000000;
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    vec_result_t e;
    cycles <= cycles + 1;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        e = pending_results.pop_front();
        if (result_x !== e.rx || result_y !== e.ry || result_scalar !== e.rs ||
            compare_true !== e.cmp || divide_by_zero !== e.dz || saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h s=%h c=%b z=%b v=%b got x=%h y=%h s=%h c=%b z=%b v=%b",
                     e.rx, e.ry, e.rs, e.cmp, e.dz, e.sat, result_x, result_y,
                     result_scalar, compare_true, divide_by_zero, saturated);
        end
      end
    end
  end

  task automatic test_field_extremes();
    logic [3:0] act;
    for (int i = 0; i < 16; i++) begin
      act = 4'(i);
      send_vector_op(act, v2alu_pkg::MAX32, v2alu_pkg::MIN32, v2alu_pkg::MIN32,
                     v2alu_pkg::MAX32, v2alu_pkg::MIN32, 1'b0);
    end
    send_vector_op(v2alu_pkg::ACT_ADD, v2alu_pkg::MAX32, v2alu_pkg::MIN32, 32'sd1, -32'sd1,
                   '0, 1'b0);
    send_vector_op(v2alu_pkg::ACT_MUL, v2alu_pkg::MAX32, v2alu_pkg::MIN32, v2alu_pkg::MAX32,
                   v2alu_pkg::MIN32, '0, 1'b0);
    send_vector_op(v2alu_pkg::ACT_DOT, v2alu_pkg::MIN32, v2alu_pkg::MIN32, v2alu_pkg::MIN32,
                   v2alu_pkg::MIN32, '0, 1'b0);
  endtask

  task automatic test_special_cases();
    send_vector_op(v2alu_pkg::ACT_DIV, 32'sd5, -32'sd5, '0, '0, '0, 1'b0);
    send_vector_op(v2alu_pkg::ACT_DIV, '0, 32'sh10000, '0, 32'sh20000, '0, 1'b0);
    send_vector_op(v2alu_pkg::ACT_SDIV, -32'sd3, '0, '0, '0, '0, 1'b0);
    send_vector_op(v2alu_pkg::ACT_NORM, '0, '0, '0, '0, '0, 1'b0);
    send_vector_op(v2alu_pkg::ACT_NORM, 32'sh30000, -32'sh40000, '0, '0, '0, 1'b0);
    send_vector_op(v2alu_pkg::ACT_EQ, 32'sd7, 32'sd9, 32'sd7, 32'sd9, '0, 1'b0);
    send_vector_op(v2alu_pkg::ACT_DIST, v2alu_pkg::MAX32, v2alu_pkg::MAX32, v2alu_pkg::MIN32,
                   v2alu_pkg::MIN32, '0, 1'b0);
  endtask

  task automatic test_random_ops(input int count);
    logic [3:0] act;
    logic signed [31:0] ax, ay;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                         : 4'($urandom_range(0, 11));
      ax = rand_operand();
      ay = rand_operand();
      if ((act == v2alu_pkg::ACT_EQ || act == v2alu_pkg::ACT_NE) && $urandom_range(0, 1))
        send_vector_op(act, ax, ay, ax, ay, rand_operand(), i % 200 >= 40);
      else
        send_vector_op(act, ax, ay, rand_operand(), rand_operand(), rand_operand(),
                       i % 200 >= 40);
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_special_cases();
    test_random_ops(950);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d vector operations over all action codes, checked %0d results",
             items_sent, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("status: fail");
    $finish;
  end
endmodule
